// File: rtl/cmap_pkg.sv
package cmap_pkg;

   localparam int NUM_VALUES          = 10;
   localparam int FIELD_W             = 32;
   localparam int HW_W                = 5;
   localparam int DEF_MAX_POINTS      = 64;
   localparam int DEF_MAX_HALF_WINDOW = 16;
   // Point counts and store addresses sized for the largest path supported.
   localparam int CNT_W               = 7;
   localparam int ADDR_W              = 6;

   typedef logic [NUM_VALUES-1:0][FIELD_W-1:0] point_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      point_type         data;
   } mem_wr_type;

   typedef struct packed {
      logic [CNT_W-1:0] n;
      logic [HW_W-1:0]  hw;
   } job_type;

endpackage

// File: rtl/cmap_fifo.sv
module cmap_fifo
   import cmap_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty,
   output logic    full
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(DEPTH + 1);

   job_type        slot_ff [DEPTH];
   logic [PW-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic           do_push, do_pop;

   assign empty    = (fill_ff == '0);
   assign full     = (fill_ff == FW'(DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rp_ff];

   always_comb begin
      wp_in   = wp_ff;
      rp_in   = rp_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wp_in = (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (do_pop) begin
         rp_in = (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         fill_ff <= fill_in;
      end
      if (do_push) begin
         slot_ff[wp_ff] <= push_data;
      end
   end

endmodule

// File: rtl/cmap_front.sv
module cmap_front
   import cmap_pkg::*;
#(
   parameter int MAX_POINTS      = DEF_MAX_POINTS,
   parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  point_type       point,
   input  logic            last,
   input  logic [HW_W-1:0] half_window,
   output mem_wr_type      mem_wr,
   output logic            job_push,
   output job_type         job
);
   localparam int CW = $clog2(MAX_POINTS + 1);

   logic [CW-1:0]   count_ff, count_in;
   logic            full;
   logic [HW_W-1:0] hw_eff;

   assign full   = (count_ff == CW'(MAX_POINTS));
   assign hw_eff = (half_window > HW_W'(MAX_HALF_WINDOW)) ? HW_W'(MAX_HALF_WINDOW)
                                                           : half_window;

   // Drop points past the store's end; the last mark still closes the path.
   assign mem_wr.we   = accept && !full;
   assign mem_wr.addr = ADDR_W'(count_ff);
   assign mem_wr.data = point;

   assign job_push = accept && last;
   assign job.n    = full ? CNT_W'(count_ff) : CNT_W'(count_ff) + 1'b1;
   assign job.hw   = hw_eff;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (last) begin
            count_in = '0;
         end else if (!full) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/cmap_back.sv
module cmap_back
   import cmap_pkg::*;
#(
   parameter int MAX_POINTS      = DEF_MAX_POINTS,
   parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW
) (
   input  logic       clock,
   input  logic       reset,
   input  mem_wr_type mem_wr,
   input  logic       job_valid,
   input  job_type    job,
   output logic       job_pop,
   output logic       busy,
   output logic       out_valid,
   input  logic       out_ready,
   output point_type  out_point,
   output logic       out_last
);
   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int DW = $clog2(2 * MAX_HALF_WINDOW + 2);
   localparam int SW = FIELD_W + DW;
   localparam int BW = $clog2(SW);
   localparam int MW = (CW > HW_W) ? CW : HW_W;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SETUP = 6'b000010,
      ST_READ  = 6'b000100,
      ST_ADD   = 6'b001000,
      ST_NORM  = 6'b010000,
      ST_DIV   = 6'b100000
   } state_type;

   point_type mem [MAX_POINTS];

   state_type                         state_ff, state_in;
   logic [CW-1:0]                     n_ff, i_ff;
   logic [HW_W-1:0]                   hw_ff;
   logic [AW-1:0]                     j_ff;
   logic [DW-1:0]                     left_ff, div_ff;
   logic [BW-1:0]                     bit_ff;
   logic [NUM_VALUES-1:0][SW-1:0]     sum_ff, mag_ff;
   logic [NUM_VALUES-1:0][DW-1:0]     r_ff;
   logic [NUM_VALUES-1:0]             neg_ff;
   point_type                         rd_ff;
   logic                              emit;
   logic                              ov_ff;
   point_type                         op_ff;
   logic                              ol_ff;

   logic [MW-1:0] i_w, tail_w, h_w;
   logic          pass;

   assign busy      = (state_ff != ST_IDLE);
   assign job_pop   = (state_ff == ST_IDLE) && job_valid;
   assign out_valid = ov_ff;
   assign out_point = op_ff;
   assign out_last  = ol_ff;

   // Shrink the window at both ends of the path.
   always_comb begin
      i_w    = MW'(i_ff);
      tail_w = MW'(n_ff) - MW'(i_ff) - 1'b1;
      h_w    = MW'(hw_ff);
      if (h_w > i_w) begin
         h_w = i_w;
      end
      if (h_w > tail_w) begin
         h_w = tail_w;
      end
   end

   assign pass = ({1'b0, job.n} <= {job.hw, 1'b0});
   assign emit = (state_ff == ST_DIV) && (bit_ff == '0) && (!ov_ff || out_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (job_valid) state_in = ST_SETUP;
         ST_SETUP: state_in = ST_READ;
         ST_READ:  state_in = ST_ADD;
         ST_ADD:   state_in = (left_ff == DW'(1)) ? ST_NORM : ST_READ;
         ST_NORM:  state_in = ST_DIV;
         ST_DIV: begin
            if (emit) begin
               state_in = (i_ff + 1'b1 == n_ff) ? ST_IDLE : ST_SETUP;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr.we) begin
         mem[mem_wr.addr[AW-1:0]] <= mem_wr.data;
      end
      if (state_ff == ST_READ) begin
         rd_ff <= mem[j_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            ov_ff <= 1'b1;
         end else if (out_ready) begin
            ov_ff <= 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            n_ff  <= CW'(job.n);
            hw_ff <= pass ? '0 : job.hw;
            i_ff  <= '0;
         end
         ST_SETUP: begin
            j_ff    <= AW'(i_w - h_w);
            left_ff <= {h_w[DW-2:0], 1'b1};
            div_ff  <= {h_w[DW-2:0], 1'b1};
            sum_ff  <= '0;
         end
         ST_READ: begin
         end
         ST_ADD: begin
            for (int k = 0; k < NUM_VALUES; k++) begin
               sum_ff[k] <= sum_ff[k] + {{DW{rd_ff[k][FIELD_W-1]}}, rd_ff[k]};
            end
            j_ff    <= j_ff + 1'b1;
            left_ff <= left_ff - 1'b1;
         end
         ST_NORM: begin
            for (int k = 0; k < NUM_VALUES; k++) begin
               neg_ff[k] <= sum_ff[k][SW-1];
               mag_ff[k] <= sum_ff[k][SW-1] ? -sum_ff[k] : sum_ff[k];
            end
            r_ff   <= '0;
            bit_ff <= BW'(SW);
         end
         ST_DIV: begin
            // Restoring divide, one quotient bit per cycle in every lane.
            if (bit_ff != '0) begin
               for (int k = 0; k < NUM_VALUES; k++) begin
                  logic [DW:0] trial;
                  trial = {r_ff[k], mag_ff[k][SW-1]};
                  if (trial >= {1'b0, div_ff}) begin
                     r_ff[k]   <= DW'(trial - {1'b0, div_ff});
                     mag_ff[k] <= {mag_ff[k][SW-2:0], 1'b1};
                  end else begin
                     r_ff[k]   <= trial[DW-1:0];
                     mag_ff[k] <= {mag_ff[k][SW-2:0], 1'b0};
                  end
               end
               bit_ff <= bit_ff - 1'b1;
            end
            if (emit) begin
               for (int k = 0; k < NUM_VALUES; k++) begin
                  op_ff[k] <= neg_ff[k] ? FIELD_W'(-mag_ff[k]) : FIELD_W'(mag_ff[k]);
               end
               ol_ff <= (i_ff + 1'b1 == n_ff);
               i_ff  <= i_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// File: rtl/centered_moving_average_path.sv
// Centered moving-average path filter.
// Send a path on the req_ channel, one point per item, ten signed Q16.16
// values each; req_in_last marks the final point. Up to MAX_POINTS points are
// stored; extra points are dropped but a last mark still ends the path.
// After the last point the block emits every stored point in order on the
// rsp_ channel, each value replaced by the average over 2h+1 neighbors, with
// h = min(half_window, MAX_HALF_WINDOW, i, N-1-i); rsp_out_last marks the
// final point. Paths of N <= 2*min(half_window, MAX_HALF_WINDOW) points come
// out unchanged. Each accepted point that fits is written straight into the
// store. While a path is being filtered the input is held off (req_ready low)
// until the back end has handed its last point to the output register.
// Each output point goes through a setup step, a store read and an add per
// window term, a sign step, a bit-serial divider (one quotient bit per cycle,
// ten lanes in parallel on one divisor) and a step that loads the output
// register. After the last item is accepted, the job passes through the
// queue and the idle state before the first setup step.
// When the receiver stalls, the finished result holds in the output register
// and the back end waits after its next divide.
// Reset clears the point count, queue and control and sets half_window to 1;
// csr_ writes are taken at any time but are meant for idle periods only.
module centered_moving_average_path
   import cmap_pkg::*;
#(
   parameter int MAX_POINTS      = DEF_MAX_POINTS,
   parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [HW_W-1:0]           csr_half_window,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [FIELD_W-1:0] req_pos_x,
   input  logic signed [FIELD_W-1:0] req_pos_y,
   input  logic signed [FIELD_W-1:0] req_pos_z,
   input  logic signed [FIELD_W-1:0] req_speed_long,
   input  logic signed [FIELD_W-1:0] req_accel,
   input  logic signed [FIELD_W-1:0] req_front_angle,
   input  logic signed [FIELD_W-1:0] req_heading_rate,
   input  logic signed [FIELD_W-1:0] req_yaw_angle,
   input  logic signed [FIELD_W-1:0] req_speed_lat,
   input  logic signed [FIELD_W-1:0] req_rear_angle,
   input  logic                      req_in_last,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [FIELD_W-1:0] rsp_avg_x,
   output logic signed [FIELD_W-1:0] rsp_avg_y,
   output logic signed [FIELD_W-1:0] rsp_avg_z,
   output logic signed [FIELD_W-1:0] rsp_avg_speed_long,
   output logic signed [FIELD_W-1:0] rsp_avg_accel,
   output logic signed [FIELD_W-1:0] rsp_avg_front_angle,
   output logic signed [FIELD_W-1:0] rsp_avg_heading_rate,
   output logic signed [FIELD_W-1:0] rsp_avg_yaw,
   output logic signed [FIELD_W-1:0] rsp_avg_speed_lat,
   output logic signed [FIELD_W-1:0] rsp_avg_rear_angle,
   output logic                      rsp_out_last
);
   logic [HW_W-1:0] hw_ff;
   logic            accept;
   point_type       point, out_point;
   mem_wr_type      mem_wr;
   logic            push, pop, q_empty, q_full, back_busy;
   job_type         push_job, pop_job;

   // Hold the register; the port never stalls.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff <= HW_W'(1);
      end else if (csr_valid) begin
         hw_ff <= csr_half_window;
      end
   end

   // Take a new item only while the store is not being read back.
   assign req_ready = q_empty && !back_busy;
   assign accept    = req_valid && req_ready;

   assign point[0] = req_pos_x;
   assign point[1] = req_pos_y;
   assign point[2] = req_pos_z;
   assign point[3] = req_speed_long;
   assign point[4] = req_accel;
   assign point[5] = req_front_angle;
   assign point[6] = req_heading_rate;
   assign point[7] = req_yaw_angle;
   assign point[8] = req_speed_lat;
   assign point[9] = req_rear_angle;

   cmap_front #(
      .MAX_POINTS      (MAX_POINTS),
      .MAX_HALF_WINDOW (MAX_HALF_WINDOW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .point       (point),
      .last        (req_in_last),
      .half_window (hw_ff),
      .mem_wr      (mem_wr),
      .job_push    (push),
      .job         (push_job)
   );

   cmap_fifo #(
      .DEPTH (2)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .pop_data  (pop_job),
      .empty     (q_empty),
      .full      (q_full)
   );

   cmap_back #(
      .MAX_POINTS      (MAX_POINTS),
      .MAX_HALF_WINDOW (MAX_HALF_WINDOW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mem_wr    (mem_wr),
      .job_valid (!q_empty),
      .job       (pop_job),
      .job_pop   (pop),
      .busy      (back_busy),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready || (q_full && 1'b0)),
      .out_point (out_point),
      .out_last  (rsp_out_last)
   );

   assign rsp_avg_x            = out_point[0];
   assign rsp_avg_y            = out_point[1];
   assign rsp_avg_z            = out_point[2];
   assign rsp_avg_speed_long   = out_point[3];
   assign rsp_avg_accel        = out_point[4];
   assign rsp_avg_front_angle  = out_point[5];
   assign rsp_avg_heading_rate = out_point[6];
   assign rsp_avg_yaw          = out_point[7];
   assign rsp_avg_speed_lat    = out_point[8];
   assign rsp_avg_rear_angle   = out_point[9];

endmodule
